// ----- rtl/tplm_pkg.sv -----
// Package with the constants, widths and sequencer states of the peak level meter.
`timescale 1ns / 1ps

package tplm_pkg;

    // Field widths.
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 15;
    localparam int LIMIT_W   = 16;
    localparam int LEVEL_W   = 7;
    localparam int COUNTED_W = 5;

    // Quotient bits produced by the divider; the level never exceeds 100.
    localparam int QUOT_W = 7;

    // Default number of kept peaks.
    localparam int PEAK_SLOTS_DEF = 16;

    // Reset value of the interval limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1023;

    // Level scaling: times one hundred, divided by the full scale of two to the fifteenth.
    localparam int PERCENT          = 100;
    localparam int FULL_SCALE_SHIFT = 15;

    // Saturated magnitude.
    localparam logic [MAG_W-1:0] MAG_MAX = 15'h7FFF;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_STEP,
        S_SHIFT,
        S_POST,
        S_SUM_RD,
        S_SUM_ACC,
        S_SCALE,
        S_DIV,
        S_OUT
    } tplm_state_t;

endpackage

// ----- rtl/tplm_if.sv -----
// Stream interfaces for sample pairs in and levels out.
`timescale 1ns / 1ps

interface tplm_sample_if
    import tplm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface tplm_level_if
    import tplm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [LEVEL_W-1:0]   level_percent;
    logic [COUNTED_W-1:0] peaks_counted;

    modport source (output valid, output level_percent, output peaks_counted, input ready);
    modport sink   (input valid, input level_percent, input peaks_counted, output ready);
endinterface

// ----- rtl/top_peaks_level_meter.sv -----
// Top level of the peak level meter: sequencer, peak list insertion and level computation.
// Flow: an item that emits no level goes from S_START to S_POST, through S_CHECK and the insertion walk
// when the list is not empty, before the next transfer is taken; the walk moves one entry per S_STEP and S_SHIFT pair.
// An emitting item then sums the kept peaks with a read and an accumulate state per peak, scales, runs
// the divider and loads the output register, and waits longer while the previous level still waits there.
// Throughput: one item at a time; the input is not ready again until the item is through.
// Reset: asynchronous, active low; clears the peak count, interval counter and output valid,
// and sets the interval limit to 1023. The list contents need no clearing.
`timescale 1ns / 1ps

module top_peaks_level_meter
    import tplm_pkg::*;
#(
    parameter int PEAK_SLOTS = PEAK_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    tplm_sample_if.sink        sample_in,
    tplm_level_if.source       level_out
);

    localparam int CNT_W = $clog2(PEAK_SLOTS + 1);
    localparam int IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
    localparam int SUM_W = MAG_W + CNT_W;
    localparam int PROD_W = SUM_W + 7;
    localparam int NUM_W = CNT_W + QUOT_W;

    tplm_state_t         state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LIMIT_W-1:0]  interval_reg, interval_next;
    logic                emit_reg, emit_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [COUNTED_W-1:0] counted_reg;
    logic                out_load;

    logic                in_xfer;
    logic signed [SAMPLE_W:0] pair_sum;
    logic [SAMPLE_W:0]   pair_abs;
    logic [SAMPLE_W-1:0] half_abs;
    logic [MAG_W-1:0]    mag_in;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [MAG_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [MAG_W-1:0]    ram_rdata;

    logic                div_start;
    logic                div_busy;
    logic [QUOT_W-1:0]   div_quot;
    logic [PROD_W-1:0]   scaled;
    logic [NUM_W-1:0]    div_num;

    logic [CNT_W-1:0]    last_idx;
    logic [CNT_W+COUNTED_W-1:0] count_wide;

    // Input transfer and magnitude of the truncated channel average.
    assign sample_in.ready = (state_reg == S_IDLE);
    assign in_xfer         = sample_in.valid && sample_in.ready;
    assign pair_sum = (SAMPLE_W+1)'(sample_in.left_sample) + (SAMPLE_W+1)'(sample_in.right_sample);
    assign pair_abs = pair_sum[SAMPLE_W] ? (SAMPLE_W+1)'(-pair_sum) : pair_sum;
    assign half_abs = pair_abs[SAMPLE_W:1];
    assign mag_in   = half_abs[SAMPLE_W-1] ? MAG_MAX : half_abs[MAG_W-1:0];

    // Index of the last kept peak.
    assign last_idx = count_reg - CNT_W'(1);

    // Mean scaling: sum times one hundred, then the full scale shift before division by the count.
    assign scaled  = PROD_W'(sum_reg) * PROD_W'(PERCENT);
    assign div_num = scaled[FULL_SCALE_SHIFT +: NUM_W];

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || level_out.ready);

    // Sequencer: interval count, insertion walk, sum over the list, scaling, division and output load.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        interval_next = interval_reg;
        emit_next     = emit_reg;
        mag_next      = mag_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = mag_reg;
        ram_raddr     = pos_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mag_next   = mag_in;
                    emit_next  = (interval_reg == limit_reg);
                    interval_next = (interval_reg == limit_reg) ? '0
                                                                : interval_reg + LIMIT_W'(1);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (count_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    count_next = CNT_W'(1);
                    state_next = S_POST;
                end
                else
                begin
                    ram_raddr  = last_idx[IDX_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (mag_reg <= ram_rdata)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    if (count_reg < CNT_W'(PEAK_SLOTS))
                    begin
                        count_next = count_reg + CNT_W'(1);
                        pos_next   = count_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        pos_next = last_idx[IDX_W-1:0];
                    end
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_POST;
                end
                else
                begin
                    ram_raddr  = pos_reg - IDX_W'(1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                ram_we = 1'b1;
                if (mag_reg > ram_rdata)
                begin
                    // The neighbour moves down one place and the walk goes on.
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_reg - IDX_W'(1);
                    state_next = S_STEP;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                pos_next = '0;
                sum_next = '0;
                if (emit_reg)
                begin
                    state_next = (count_reg == '0) ? S_SCALE : S_SUM_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                sum_next = sum_reg + SUM_W'(ram_rdata);
                if (CNT_W'(pos_reg) == last_idx)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    pos_next   = pos_reg + IDX_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_SCALE:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a finished level waits here while the next sample is taken.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (level_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign count_wide = {{COUNTED_W{1'b0}}, count_reg};

    // Control registers and the limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            interval_reg  <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        emit_reg <= emit_next;
        mag_reg  <= mag_next;
        pos_reg  <= pos_next;
        sum_reg  <= sum_next;
        if (out_load)
        begin
            level_reg   <= (count_reg == '0) ? '0 : div_quot;
            counted_reg <= count_wide[COUNTED_W-1:0];
        end
    end

    assign level_out.valid         = out_valid_reg;
    assign level_out.level_percent = level_reg;
    assign level_out.peaks_counted = counted_reg;

    // Peak list store.
    tplm_peak_ram #(
        .DEPTH  (PEAK_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Divider by the peak count.
    tplm_divider #(
        .DEN_W (CNT_W),
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

endmodule

// ----- rtl/tplm_peak_ram.sv -----
// Peak list store: one write port and one registered read port.
`timescale 1ns / 1ps

module tplm_peak_ram
    import tplm_pkg::*;
#(
    parameter int DEPTH  = PEAK_SLOTS_DEF,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [MAG_W-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [MAG_W-1:0]  rd_data
);

    logic [MAG_W-1:0] mem [DEPTH];
    logic [MAG_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tplm_divider.sv -----
// Restoring divider that produces one quotient bit per cycle with a shared compare and subtract.
`timescale 1ns / 1ps

module tplm_divider
    import tplm_pkg::*;
#(
    parameter int DEN_W = 5,
    parameter int NUM_W = DEN_W + QUOT_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic              busy,
    output logic [QUOT_W-1:0] quotient
);

    localparam int BIT_W = $clog2(QUOT_W);

    logic              busy_reg, busy_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [NUM_W-1:0]  trial_den;
    logic              take;

    // Divisor aligned to the current quotient bit and the trial compare.
    assign trial_den = NUM_W'(den_reg) << bit_reg;
    assign take      = (rem_reg >= trial_den);

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        busy_next = busy_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = BIT_W'(QUOT_W - 1);
            rem_next  = dividend;
            den_next  = divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_next  = rem_reg - trial_den;
                quot_next = quot_reg | (QUOT_W'(1) << bit_reg);
            end
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                bit_next = bit_reg - BIT_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ----- rtl/tplm_checker.sv -----
// Port checker for the peak level meter and its bind to the top level.
`timescale 1ns / 1ps

module tplm_checker
    import tplm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [LEVEL_W-1:0]   level_percent,
    input logic [COUNTED_W-1:0] peaks_counted
);

    // A stalled level stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level_percent)
                                    && $stable(peaks_counted))
        else $error("stalled level changed or was withdrawn");

    // The block works on one sample pair at a time.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again straight after a transfer");

    // A level never exceeds full scale.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level_percent <= LEVEL_W'(PERCENT))
        else $error("level above one hundred percent");

    // A new level appears only while a sample pair is being worked on.
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("level appeared while the block was idle");

endmodule

bind top_peaks_level_meter tplm_checker u_tplm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_in.valid),
    .in_ready      (sample_in.ready),
    .out_valid     (level_out.valid),
    .out_ready     (level_out.ready),
    .level_percent (level_out.level_percent),
    .peaks_counted (level_out.peaks_counted)
);
